### design/ctks_pkg.sv
// ----------------------------------------------------------------------------
// ctks_pkg
// Shared types and constants for the counting tree k-th select block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctks_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam int SLOT_W   = 10;
    localparam int DELTA_W  = 9;
    localparam int RANK_W   = 16;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANK  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ADD = 1'b0,
        KIND_SEL = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_LEAF,
        S_ADD_CHECK,
        S_ADD_WALK,
        S_SEL_START,
        S_SEL_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

### design/ctks_count_mem.sv
// ----------------------------------------------------------------------------
// ctks_count_mem
// Node count store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ctks_count_mem #(
    parameter int DEPTH = 2 * ctks_pkg::SLOTS_DEF,
    parameter int DW    = ctks_pkg::COUNT_BITS_DEF
) (
    input  wire                     i_clk,
    input  ctks_pkg::t_mem_ctl      i_ctl,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [DW-1:0]            i_wr_data,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]           o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/ctks_path_step.sv
// ----------------------------------------------------------------------------
// ctks_path_step
// Path arithmetic for one tree level: midpoint, node addresses of the current
// span and of the chosen child span.
// ----------------------------------------------------------------------------
`default_nettype none

module ctks_path_step #(
    parameter int SLOTS = ctks_pkg::SLOTS_DEF
) (
    input  wire [$clog2(SLOTS)-1:0]  i_lo,
    input  wire [$clog2(SLOTS)-1:0]  i_hi,
    input  wire                      i_go_left,
    output logic [$clog2(SLOTS)-1:0] o_mid,
    output logic [$clog2(SLOTS):0]   o_cur_own,
    output logic [$clog2(SLOTS):0]   o_cur_lchild,
    output logic                     o_last,
    output logic [$clog2(SLOTS)-1:0] o_nxt_lo,
    output logic [$clog2(SLOTS)-1:0] o_nxt_hi,
    output logic [$clog2(SLOTS):0]   o_nxt_own,
    output logic [$clog2(SLOTS):0]   o_nxt_lchild,
    output logic                     o_nxt_last
);

    localparam int SW = $clog2(SLOTS);
    localparam int AW = SW + 1;

    function automatic logic [SW-1:0] f_mid(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [AW-1:0] s;
        s = AW'(a) + AW'(b);
        return s[AW-1:1];
    endfunction

    function automatic logic [AW-1:0] f_node(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [AW-1:0] s;
        s = AW'(a) + AW'(b);
        return {s[AW-1:1], s[0] | (a != b)};
    endfunction

    logic [SW-1:0] w_mid;
    logic [SW-1:0] w_r_lo;

    always_comb begin
        w_mid  = f_mid(i_lo, i_hi);
        w_r_lo = w_mid + SW'(1);
    end

    always_comb begin
        o_mid        = w_mid;
        o_cur_own    = f_node(i_lo, i_hi);
        o_cur_lchild = f_node(i_lo, w_mid);
        o_last       = (i_lo == i_hi);
        if (i_go_left) begin
            o_nxt_lo     = i_lo;
            o_nxt_hi     = w_mid;
            o_nxt_own    = f_node(i_lo, w_mid);
            o_nxt_lchild = f_node(i_lo, f_mid(i_lo, w_mid));
            o_nxt_last   = (i_lo == w_mid);
        end else begin
            o_nxt_lo     = w_r_lo;
            o_nxt_hi     = i_hi;
            o_nxt_own    = f_node(w_r_lo, i_hi);
            o_nxt_lchild = f_node(w_r_lo, f_mid(w_r_lo, i_hi));
            o_nxt_last   = (w_r_lo == i_hi);
        end
    end

endmodule

`default_nettype wire

### design/ctks_seq.sv
// ----------------------------------------------------------------------------
// ctks_seq
// Sequencer: clears the store, walks the tree one level per cycle for add
// and select items, and holds the finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module ctks_seq #(
    parameter int SLOTS      = ctks_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = ctks_pkg::COUNT_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [$clog2(SLOTS):0]               i_slots,
    input  wire                                 i_clear,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_kind,
    input  wire [ctks_pkg::SLOT_W-1:0]          i_slot,
    input  wire signed [ctks_pkg::DELTA_W-1:0]  i_delta,
    input  wire [ctks_pkg::RANK_W-1:0]          i_rank,
    output logic                                o_res_valid,
    input  wire                                 i_res_take,
    output ctks_pkg::t_status                   o_res_status,
    output logic [$clog2(SLOTS)-1:0]            o_res_found
);

    localparam int SW     = $clog2(SLOTS);
    localparam int AW     = SW + 1;
    localparam int NW     = SW + 1;
    localparam int DEPTH  = 2 * SLOTS;
    localparam int CB     = COUNT_BITS;
    localparam int RW     = ctks_pkg::RANK_W;
    localparam int KW     = (CB > RW) ? CB : RW;
    localparam int EW     = ((CB > ctks_pkg::DELTA_W) ? CB : ctks_pkg::DELTA_W) + 2;
    localparam int WW     = (NW > ctks_pkg::SLOT_W) ? NW : ctks_pkg::SLOT_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
    localparam logic signed [EW-1:0] CNT_MAX = $signed({{(EW-CB){1'b0}}, {CB{1'b1}}});

    ctks_pkg::t_state  r_state, n_state;
    logic [AW-1:0]     r_clr;
    logic [SW-1:0]     r_lo, r_hi;
    logic [SW-1:0]     r_slot;
    logic signed [ctks_pkg::DELTA_W-1:0] r_delta;
    logic [RW-1:0]     r_k;
    logic [CB-1:0]     r_total;
    ctks_pkg::t_status r_status;
    logic [SW-1:0]     r_found;

    ctks_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]      w_wr_addr, w_rd_addr;
    logic [CB-1:0]      w_wr_data, w_q;

    logic [SW-1:0] w_mid, w_nxt_lo, w_nxt_hi;
    logic [AW-1:0] w_cur_own, w_cur_lchild, w_nxt_own, w_nxt_lchild;
    logic          w_last, w_nxt_last, w_go_left;

    logic [SW-1:0]          w_root_hi;
    logic [WW-1:0]          w_slot_ext;
    logic                   w_slot_ok, w_rank_bad, w_one_slot;
    logic signed [EW-1:0]   w_leaf_new, w_tot_new;
    logic                   w_add_bad;
    logic                   w_sel_left, w_add_left;
    logic [KW-1:0]          w_k_diff;

    ctks_count_mem #(
        .DEPTH (DEPTH),
        .DW    (CB)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_q)
    );

    ctks_path_step #(
        .SLOTS (SLOTS)
    ) u_step (
        .i_lo         (r_lo),
        .i_hi         (r_hi),
        .i_go_left    (w_go_left),
        .o_mid        (w_mid),
        .o_cur_own    (w_cur_own),
        .o_cur_lchild (w_cur_lchild),
        .o_last       (w_last),
        .o_nxt_lo     (w_nxt_lo),
        .o_nxt_hi     (w_nxt_hi),
        .o_nxt_own    (w_nxt_own),
        .o_nxt_lchild (w_nxt_lchild),
        .o_nxt_last   (w_nxt_last)
    );

    always_comb begin
        w_root_hi  = SW'(i_slots - NW'(1));
        w_slot_ext = WW'(i_slot);
        w_slot_ok  = w_slot_ext < WW'(i_slots);
        w_rank_bad = (i_rank == '0) || (KW'(i_rank) > KW'(r_total));
        w_one_slot = (i_slots == NW'(1));
        w_leaf_new = $signed({{(EW-CB){1'b0}}, w_q}) + EW'(r_delta);
        w_tot_new  = $signed({{(EW-CB){1'b0}}, r_total}) + EW'(r_delta);
        w_add_bad  = (w_leaf_new < 0) || (w_tot_new > CNT_MAX);
        w_sel_left = KW'(w_q) >= KW'(r_k);
        w_add_left = r_slot <= w_mid;
        w_k_diff   = KW'(r_k) - KW'(w_q);
        w_go_left  = (r_state == ctks_pkg::S_SEL_WALK) ? w_sel_left : w_add_left;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctks_pkg::S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = ctks_pkg::S_IDLE;
                end
            end
            ctks_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == ctks_pkg::KIND_ADD) begin
                        n_state = w_slot_ok ? ctks_pkg::S_ADD_LEAF : ctks_pkg::S_DONE;
                    end else if (w_rank_bad || w_one_slot) begin
                        n_state = ctks_pkg::S_DONE;
                    end else begin
                        n_state = ctks_pkg::S_SEL_START;
                    end
                end
            end
            ctks_pkg::S_ADD_LEAF:  n_state = ctks_pkg::S_ADD_CHECK;
            ctks_pkg::S_ADD_CHECK: begin
                n_state = w_add_bad ? ctks_pkg::S_DONE : ctks_pkg::S_ADD_WALK;
            end
            ctks_pkg::S_ADD_WALK: begin
                if (w_last) begin
                    n_state = ctks_pkg::S_DONE;
                end
            end
            ctks_pkg::S_SEL_START: n_state = ctks_pkg::S_SEL_WALK;
            ctks_pkg::S_SEL_WALK: begin
                if (w_nxt_last) begin
                    n_state = ctks_pkg::S_DONE;
                end
            end
            ctks_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = ctks_pkg::S_IDLE;
                end
            end
        endcase
        if (i_clear) begin
            n_state = ctks_pkg::S_CLEAR;
        end
    end

    // memory port and handshake outputs
    always_comb begin
        w_mem_ctl   = '0;
        w_wr_addr   = w_cur_own;
        w_wr_data   = w_q + CB'(r_delta);
        w_rd_addr   = w_cur_own;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ctks_pkg::S_CLEAR: begin
                w_mem_ctl.wr_en = 1'b1;
                w_wr_addr       = r_clr;
                w_wr_data       = '0;
            end
            ctks_pkg::S_IDLE: begin
                o_in_ready = !i_clear;
            end
            ctks_pkg::S_ADD_LEAF: begin
                w_mem_ctl.rd_en = 1'b1;
                w_rd_addr       = {r_slot, 1'b0};
            end
            ctks_pkg::S_ADD_CHECK: begin
                w_mem_ctl.rd_en = 1'b1;
                w_rd_addr       = w_cur_own;
            end
            ctks_pkg::S_ADD_WALK: begin
                w_mem_ctl.wr_en = 1'b1;
                w_mem_ctl.rd_en = !w_last;
                w_rd_addr       = w_nxt_own;
            end
            ctks_pkg::S_SEL_START: begin
                w_mem_ctl.rd_en = 1'b1;
                w_rd_addr       = w_cur_lchild;
            end
            ctks_pkg::S_SEL_WALK: begin
                w_mem_ctl.rd_en = !w_nxt_last;
                w_rd_addr       = w_nxt_lchild;
            end
            ctks_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctks_pkg::S_CLEAR;
            r_clr   <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_clr   <= '0;
                r_total <= '0;
            end else if (r_state == ctks_pkg::S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end else if (r_state == ctks_pkg::S_ADD_CHECK && !w_add_bad) begin
                r_total <= w_tot_new[CB-1:0];
            end
        end
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ctks_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_slot  <= w_slot_ext[SW-1:0];
                    r_delta <= i_delta;
                    r_k     <= i_rank;
                    r_lo    <= '0;
                    r_hi    <= w_root_hi;
                    r_found <= '0;
                    if (i_kind == ctks_pkg::KIND_ADD) begin
                        r_status <= w_slot_ok ? ctks_pkg::ST_OK : ctks_pkg::ST_RANGE;
                    end else begin
                        r_status <= w_rank_bad ? ctks_pkg::ST_RANK : ctks_pkg::ST_OK;
                    end
                end
            end
            ctks_pkg::S_ADD_CHECK: begin
                if (w_add_bad) begin
                    r_status <= ctks_pkg::ST_RANGE;
                end
            end
            ctks_pkg::S_ADD_WALK: begin
                if (!w_last) begin
                    r_lo <= w_nxt_lo;
                    r_hi <= w_nxt_hi;
                end
            end
            ctks_pkg::S_SEL_WALK: begin
                r_lo <= w_nxt_lo;
                r_hi <= w_nxt_hi;
                if (!w_sel_left) begin
                    r_k <= w_k_diff[RW-1:0];
                end
                if (w_nxt_last) begin
                    r_found <= w_nxt_lo;
                end
            end
            ctks_pkg::S_CLEAR, ctks_pkg::S_ADD_LEAF, ctks_pkg::S_SEL_START,
            ctks_pkg::S_DONE: begin
            end
        endcase
    end

    assign o_res_status = r_status;
    assign o_res_found  = r_found;

endmodule

`default_nettype wire

### design/counting_tree_kth_select.sv
// Add item: reads the leaf, checks the new counts, then updates each node from root to leaf.
// Select item: reads left-child counts from the root down and steers by the rank.
// Rejected slot or rank, or an add rejected on its count, ends the item early.
// One item at a time; the next item is accepted the cycle after its result is registered.
// After reset and after every slots_in_use write the store's 2*SLOTS nodes
// (2048 by default) are swept clear with the input not ready.
// ----------------------------------------------------------------------------
// counting_tree_kth_select
// Counting tree over value slots with signed count updates and k-th smallest
// selection.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_tree_kth_select #(
    parameter int SLOTS      = ctks_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = ctks_pkg::COUNT_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [ctks_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_kind,
    input  wire [ctks_pkg::SLOT_W-1:0]         i_slot,
    input  wire signed [ctks_pkg::DELTA_W-1:0] i_delta,
    input  wire [ctks_pkg::RANK_W-1:0]         i_rank,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [ctks_pkg::STATUS_W-1:0]      o_status,
    output logic [ctks_pkg::SLOT_W-1:0]        o_found_slot
);

    localparam int SW = $clog2(SLOTS);
    localparam int NW = SW + 1;
    localparam int CW = (NW > ctks_pkg::CFG_W) ? NW : ctks_pkg::CFG_W;
    localparam int FW = (SW > ctks_pkg::SLOT_W) ? SW : ctks_pkg::SLOT_W;

    logic [NW-1:0]     r_slots;
    logic [CW-1:0]     w_cfg_ext, w_cfg_clamp;
    logic              w_res_valid, w_res_take;
    ctks_pkg::t_status w_res_status;
    logic [SW-1:0]     w_res_found;
    logic [FW-1:0]     w_found_ext;

    logic                          r_out_valid;
    logic [ctks_pkg::STATUS_W-1:0] r_out_status;
    logic [ctks_pkg::SLOT_W-1:0]   r_out_found;

    always_comb begin
        w_cfg_ext = CW'(i_cfg_data);
        if (w_cfg_ext == '0) begin
            w_cfg_clamp = CW'(1);
        end else if (w_cfg_ext > CW'(SLOTS)) begin
            w_cfg_clamp = CW'(SLOTS);
        end else begin
            w_cfg_clamp = w_cfg_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= NW'(SLOTS);
        end else if (i_cfg_valid) begin
            r_slots <= w_cfg_clamp[NW-1:0];
        end
    end

    assign o_cfg_ready = 1'b1;

    ctks_seq #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slots      (r_slots),
        .i_clear      (i_cfg_valid),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_slot       (i_slot),
        .i_delta      (i_delta),
        .i_rank       (i_rank),
        .o_res_valid  (w_res_valid),
        .i_res_take   (w_res_take),
        .o_res_status (w_res_status),
        .o_res_found  (w_res_found)
    );

    assign w_res_take  = w_res_valid && (!r_out_valid || i_out_ready);
    assign w_found_ext = FW'(w_res_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_status <= w_res_status;
            r_out_found  <= w_found_ext[ctks_pkg::SLOT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_found_slot = r_out_found;

endmodule

`default_nettype wire

### design/ctks_checker.sv
// ----------------------------------------------------------------------------
// ctks_checker
// Port-level checks for the counting tree k-th select block.
// ----------------------------------------------------------------------------
`default_nettype none

module ctks_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_cfg_valid,
    input wire                                o_cfg_ready,
    input wire                                i_in_valid,
    input wire                                o_in_ready,
    input wire                                o_out_valid,
    input wire                                i_out_ready,
    input wire [ctks_pkg::STATUS_W-1:0]       o_status,
    input wire [ctks_pkg::SLOT_W-1:0]         o_found_slot
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_found_slot))
        else $error("result changed while stalled");

    // one item in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // register write starts the clearing sweep
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_in_ready)
        else $error("input ready right after a register write");

    // rejected items carry no slot
    a_reject_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ctks_pkg::ST_OK) |-> o_found_slot == '0)
        else $error("rejected item with nonzero slot");

endmodule

bind counting_tree_kth_select ctks_checker u_ctks_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_found_slot (o_found_slot)
);

`default_nettype wire
